// ===== rtl/core/b2ra_pkg.sv =====
// Shared types, constants and helper functions of the binary to radix ASCII converter.
// Depends on nothing; every other file of the block uses it.
package b2ra_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_DIGITS_DEF  = 32;

    localparam int DIGIT_W = 4;
    localparam int BASE_W  = 5;
    localparam int CHAR_W  = 7;

    localparam logic [BASE_W-1:0]  RADIX_RESET = 5'd10;
    localparam logic [BASE_W-1:0]  RADIX_MIN   = 5'd2;
    localparam logic [BASE_W-1:0]  RADIX_MAX   = 5'd16;
    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0]  ASCII_A     = 7'd65;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 4'd10;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_EMIT
    } t_state;

    // Per-cycle command broadcast to every digit cell.
    typedef struct packed {
        logic clear;
        logic conv;
        logic shift;
    } t_cell_ctrl;

    function automatic logic [BASE_W-1:0] effective_radix(input logic [BASE_W-1:0] radix);
        logic [BASE_W-1:0] r;
        if (radix < RADIX_MIN) begin
            r = RADIX_MIN;
        end else if (radix > RADIX_MAX) begin
            r = RADIX_MAX;
        end else begin
            r = radix;
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_TEN) begin
            c = ASCII_ZERO + CHAR_W'(d);
        end else begin
            c = ASCII_A + CHAR_W'(d - DIGIT_TEN);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/b2ra_if.sv =====
// Valid/ready channel interfaces for the input numbers and the output characters.
// Depends on b2ra_pkg for the default and fixed field widths.
interface b2ra_in_if #(
    parameter int VALUE_WIDTH = b2ra_pkg::VALUE_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface b2ra_out_if;
    logic                        valid;
    logic                        ready;
    logic [b2ra_pkg::CHAR_W-1:0] char_code;
    logic                        last_digit;

    modport source (output valid, output char_code, output last_digit, input ready);
    modport sink   (input valid, input char_code, input last_digit, output ready);
endinterface

// ===== rtl/core/b2ra_cell.sv =====
// One digit cell of the conversion chain: clears its digit, doubles it and adds the incoming bit
// modulo the radix, or shifts in its neighbour's digit. Depends on b2ra_pkg.
module b2ra_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  b2ra_pkg::t_cell_ctrl         i_ctrl,
    input  logic [b2ra_pkg::BASE_W-1:0]  i_base,
    input  logic                         i_tok,
    input  logic                         i_carry,
    input  logic [b2ra_pkg::DIGIT_W-1:0] i_digit,
    output logic [b2ra_pkg::DIGIT_W-1:0] o_digit,
    output logic                         o_tok,
    output logic                         o_carry
);

    logic [b2ra_pkg::DIGIT_W-1:0] r_digit, n_digit;
    logic                         r_tok, n_tok;
    logic                         r_carry, n_carry;

    logic [b2ra_pkg::BASE_W-1:0]  w_twice;
    logic                         w_ge;
    logic [b2ra_pkg::DIGIT_W-1:0] w_new;

    // The digit is below the radix, so twice it plus one is below twice the radix
    // and a single conditional subtract reduces it.
    assign w_twice = {r_digit, i_carry};
    assign w_ge    = (w_twice >= i_base);
    assign w_new   = w_ge ? b2ra_pkg::DIGIT_W'(w_twice - i_base) : w_twice[b2ra_pkg::DIGIT_W-1:0];

    always_comb begin
        n_digit = r_digit;
        n_tok   = 1'b0;
        n_carry = r_carry;
        if (i_ctrl.clear) begin
            n_digit = '0;
        end else if (i_ctrl.conv) begin
            n_tok = i_tok;
            if (i_tok) begin
                n_digit = w_new;
                n_carry = w_ge;
            end
        end else if (i_ctrl.shift) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit <= '0;
            r_tok   <= 1'b0;
            r_carry <= 1'b0;
        end else begin
            r_digit <= n_digit;
            r_tok   <= n_tok;
            r_carry <= n_carry;
        end
    end

    assign o_digit = r_digit;
    assign o_tok   = r_tok;
    assign o_carry = r_carry;

endmodule

// ===== rtl/core/binary_to_radix_ascii.sv =====
// Top level of the binary to radix ASCII converter: control sequencer and a chain of
// digit cells. Depends on b2ra_pkg, b2ra_if (b2ra_in_if, b2ra_out_if) and b2ra_cell.

// Each accepted word is an unsigned number that the block writes out as ASCII digits in
// the radix held in the configuration register (2..16; 0 and 1 act as 2, 17..31 as 16),
// most significant digit first, without leading zeros, one output word per digit, with
// last_digit set on the final one. Zero gives the single digit '0'. The radix is sampled
// when a number is accepted, so it should only be written while the block is idle. When the
// output side is always ready, the time an item takes is the same whatever its digit count,
// as the digit cell chain sets it: the input bits enter cell zero one per cycle and each
// doubling ripples up one cell per cycle until the last one leaves the top cell; the chain
// then shifts upwards one digit per cycle, first past the leading zeros and then, as long as
// the output register can take a word, emitting each digit from the top cell, with a turn
// from skipping to emitting in between. A new number is taken as soon as the last digit of
// the previous one sits in the output register, even if that word has not yet been taken.
// Numbers needing more than MAX_DIGITS digits keep only their MAX_DIGITS least significant
// digits.
module binary_to_radix_ascii #(
    parameter int VALUE_WIDTH = b2ra_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = b2ra_pkg::MAX_DIGITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [b2ra_pkg::BASE_W-1:0] i_cfg_data,
    b2ra_in_if.sink                     i_in,
    b2ra_out_if.source                  o_out
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + MAX_DIGITS - 1);
    localparam int REM_W = $clog2(MAX_DIGITS + 1);
    localparam logic [CNT_W-1:0] CNT_BITS = CNT_W'(VALUE_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH + MAX_DIGITS - 2);
    localparam logic [REM_W-1:0] REM_FULL = REM_W'(MAX_DIGITS);
    localparam logic [REM_W-1:0] REM_ONE  = REM_W'(1);

    // Configuration register and the radix latched for the number in progress.
    logic [b2ra_pkg::BASE_W-1:0] r_radix;
    logic [b2ra_pkg::BASE_W-1:0] r_base;

    b2ra_pkg::t_state r_state, n_state;

    // Input bits still to be fed, most significant first, and the phase counters.
    logic [VALUE_WIDTH-1:0] r_value;
    logic [CNT_W-1:0]       r_cnt;
    logic [REM_W-1:0]       r_rem;

    // Output register that parts the chain from the downstream side.
    logic                        r_out_valid;
    logic [b2ra_pkg::CHAR_W-1:0] r_out_char;
    logic                        r_out_last;

    b2ra_pkg::t_cell_ctrl w_ctrl;
    logic                 w_accept;
    logic                 w_skip_go;
    logic                 w_out_load;

    logic [b2ra_pkg::DIGIT_W-1:0] w_digit [MAX_DIGITS];
    logic                         w_tok   [MAX_DIGITS];
    logic                         w_carry [MAX_DIGITS];
    logic [b2ra_pkg::DIGIT_W-1:0] w_top;

    assign w_top = w_digit[MAX_DIGITS-1];

    // The chain of digit cells. Cell zero holds the least significant digit; its
    // doubling token comes from the sequencer and its incoming bit from the input shift
    // register, and every other cell takes the registered carry of the cell below. During
    // the shift phases digits move one cell upwards and zero enters at the bottom.
    for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
        logic                         w_tok_in;
        logic                         w_carry_in;
        logic [b2ra_pkg::DIGIT_W-1:0] w_digit_in;

        if (k == 0) begin : g_first
            assign w_tok_in   = (r_state == b2ra_pkg::S_CONV) && (r_cnt < CNT_BITS);
            assign w_carry_in = r_value[VALUE_WIDTH-1];
            assign w_digit_in = '0;
        end else begin : g_rest
            assign w_tok_in   = w_tok[k-1];
            assign w_carry_in = w_carry[k-1];
            assign w_digit_in = w_digit[k-1];
        end

        b2ra_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_base  (r_base),
            .i_tok   (w_tok_in),
            .i_carry (w_carry_in),
            .i_digit (w_digit_in),
            .o_digit (w_digit[k]),
            .o_tok   (w_tok[k]),
            .o_carry (w_carry[k])
        );
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            b2ra_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = b2ra_pkg::S_CONV;
                end
            end
            b2ra_pkg::S_CONV: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = b2ra_pkg::S_SKIP;
                end
            end
            b2ra_pkg::S_SKIP: begin
                if (!w_skip_go) begin
                    n_state = b2ra_pkg::S_EMIT;
                end
            end
            b2ra_pkg::S_EMIT: begin
                if (w_out_load && (r_rem == REM_ONE)) begin
                    n_state = b2ra_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = b2ra_pkg::S_IDLE;
            end
        endcase
    end

    // Control outputs. A leading zero is dropped while more than one digit remains, so
    // zero still gives a single '0'.
    always_comb begin
        i_in.ready   = 1'b0;
        w_skip_go    = 1'b0;
        w_out_load   = 1'b0;
        w_ctrl.conv  = 1'b0;
        w_ctrl.shift = 1'b0;
        case (r_state)
            b2ra_pkg::S_IDLE: begin
                i_in.ready = 1'b1;
            end
            b2ra_pkg::S_CONV: begin
                w_ctrl.conv = 1'b1;
            end
            b2ra_pkg::S_SKIP: begin
                w_skip_go    = (w_top == '0) && (r_rem > REM_ONE);
                w_ctrl.shift = w_skip_go;
            end
            b2ra_pkg::S_EMIT: begin
                w_out_load   = !r_out_valid || o_out.ready;
                w_ctrl.shift = w_out_load;
            end
            default: begin
                i_in.ready = 1'b0;
            end
        endcase
        w_accept     = i_in.valid && i_in.ready;
        w_ctrl.clear = w_accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= b2ra_pkg::S_IDLE;
            r_radix     <= b2ra_pkg::RADIX_RESET;
            r_base      <= b2ra_pkg::RADIX_RESET;
            r_cnt       <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_radix <= i_cfg_data;
            end
            if (w_accept) begin
                r_base <= b2ra_pkg::effective_radix(r_radix);
                r_cnt  <= '0;
                r_rem  <= REM_FULL;
            end else if (r_state == b2ra_pkg::S_CONV) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (w_ctrl.shift) begin
                r_rem <= r_rem - REM_ONE;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value <= VALUE_WIDTH'(i_in.value);
        end else if (r_state == b2ra_pkg::S_CONV) begin
            r_value <= {r_value[VALUE_WIDTH-2:0], 1'b0};
        end
        if (w_out_load) begin
            r_out_char <= b2ra_pkg::digit_char(w_top);
            r_out_last <= (r_rem == REM_ONE);
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.char_code  = r_out_char;
    assign o_out.last_digit = r_out_last;

    // The digit counter never runs out while digits are being skipped or emitted.
    a_rem_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == b2ra_pkg::S_SKIP || r_state == b2ra_pkg::S_EMIT) |-> (r_rem != '0))
        else $error("digit counter empty while emitting");

    // Returning to idle always leaves the final digit of the number in the output register.
    a_last_on_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == b2ra_pkg::S_EMIT && n_state == b2ra_pkg::S_IDLE)
        |=> (r_out_valid && r_out_last))
        else $error("number finished without a last digit word");

    // Doubling tokens reach the top cell only at the end of conversion.
    a_tok_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[MAX_DIGITS-1] |-> (r_state == b2ra_pkg::S_CONV || r_state == b2ra_pkg::S_SKIP))
        else $error("doubling token in top cell outside conversion");

    // Every digit that is skipped or emitted is a proper digit of the latched radix.
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == b2ra_pkg::S_SKIP || r_state == b2ra_pkg::S_EMIT)
        |-> ({1'b0, w_top} < r_base))
        else $error("top cell digit not below the radix");

endmodule

// ===== tb/b2ra_digit_checker.sv =====
`timescale 1ns / 1ps
// Checker for the binary to radix ASCII converter: watches both channels, predicts digits.
// Depends on b2ra_pkg and on the channel interfaces in b2ra_if.
module b2ra_digit_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [b2ra_pkg::BASE_W-1:0] i_cfg_data,
    b2ra_in_if                          i_in,
    b2ra_out_if                         i_out,
    output int                          o_mismatches,
    output int                          o_pending
);

    typedef struct packed {
        logic [b2ra_pkg::CHAR_W-1:0] char_code;
        logic                        last_digit;
    } t_digit_word;

    t_digit_word                 expected_words[$];
    logic [b2ra_pkg::BASE_W-1:0] radix_reg;
    int                          mismatch_total = 0;

    function automatic logic [b2ra_pkg::BASE_W-1:0] clamp_radix(
        input logic [b2ra_pkg::BASE_W-1:0] r
    );
        return (r < b2ra_pkg::RADIX_MIN) ? b2ra_pkg::RADIX_MIN :
               ((r > b2ra_pkg::RADIX_MAX) ? b2ra_pkg::RADIX_MAX : r);
    endfunction

    function automatic logic [b2ra_pkg::CHAR_W-1:0] ascii_of_digit(
        input logic [b2ra_pkg::DIGIT_W-1:0] d
    );
        return (d < b2ra_pkg::DIGIT_TEN) ?
               b2ra_pkg::ASCII_ZERO + b2ra_pkg::CHAR_W'(d) :
               b2ra_pkg::ASCII_A + b2ra_pkg::CHAR_W'(d - b2ra_pkg::DIGIT_TEN);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_total++;
    endtask

    // Divides the number down, least significant digit first, then queues the digits
    // in the order in which they leave the block.
    task automatic queue_digits(input logic [b2ra_pkg::VALUE_WIDTH_DEF-1:0] number);
        logic [b2ra_pkg::DIGIT_W-1:0]         digits[b2ra_pkg::MAX_DIGITS_DEF];
        logic [b2ra_pkg::VALUE_WIDTH_DEF-1:0] rest;
        logic [b2ra_pkg::VALUE_WIDTH_DEF-1:0] base;
        int                                   count;
        t_digit_word                          word;
        base  = b2ra_pkg::VALUE_WIDTH_DEF'(clamp_radix(radix_reg));
        rest  = number;
        count = 0;
        do begin
            digits[count] = b2ra_pkg::DIGIT_W'(rest % base);
            rest = rest / base;
            count++;
        end while (rest != 0 && count < b2ra_pkg::MAX_DIGITS_DEF);
        for (int k = count - 1; k >= 0; k--) begin
            word.char_code  = ascii_of_digit(digits[k]);
            word.last_digit = (k == 0);
            expected_words.push_back(word);
        end
    endtask

    task automatic check_word(input logic [b2ra_pkg::CHAR_W-1:0] got_char,
                              input logic got_last);
        t_digit_word want;
        if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word char=%0d last=%b", got_char, got_last));
        end else begin
            want = expected_words.pop_front();
            if (got_char !== want.char_code) begin
                report_mismatch($sformatf("char_code %0d, expected %0d",
                                          got_char, want.char_code));
            end
            if (got_last !== want.last_digit) begin
                report_mismatch($sformatf("last_digit %b, expected %b",
                                          got_last, want.last_digit));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            radix_reg = b2ra_pkg::RADIX_RESET;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                radix_reg = i_cfg_data;
            end
            if (i_out.valid && i_out.ready) begin
                check_word(i_out.char_code, i_out.last_digit);
            end
            if (i_in.valid && i_in.ready) begin
                queue_digits(i_in.value);
            end
        end
        o_mismatches <= mismatch_total;
        o_pending    <= expected_words.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the testbench for binary_to_radix_ascii: clock, reset, stimulus and verdict.
// Depends on b2ra_pkg, b2ra_if, the block itself and b2ra_digit_checker.
module testbench;

    // Bound for the watchdog, with ample room over the slowest correct run.
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int LONG_HOLD       = 400;
    // Longer than one number takes inside the block, so this settles everything.
    localparam int SETTLE_CYCLES   = 150;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        cfg_we;
    logic [b2ra_pkg::BASE_W-1:0] cfg_data;
    int                          mismatches;
    int                          pending_words;
    int                          cycle_count = 0;

    // Flags shared between the sender and the receiver processes. Each one has a
    // single writer: the stimulus process owns idle_on and hold_request, the
    // receiver owns hold_served.
    bit idle_on = 1'b1;
    bit hold_request = 1'b0;
    bit hold_served = 1'b0;

    b2ra_in_if  in_ch ();
    b2ra_out_if out_ch ();

    binary_to_radix_ascii dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    b2ra_digit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending_words)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake or a digit that never arrives ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver. It stalls in random bursts while idling is allowed, and once, on
    // request, holds off for a long stretch so that the block fills up and has to
    // refuse the sender's next word.
    initial begin
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Offers one number and returns at the edge where it is taken. Valid stays high
    // afterwards, so back-to-back words need no second assignment in that step.
    task automatic send_number(input logic [b2ra_pkg::VALUE_WIDTH_DEF-1:0] number);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= number;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Waits until the checker holds no outstanding digit, then waits on so that the
    // block is certainly back at rest.
    task automatic wait_until_drained();
        do @(posedge i_clk); while (pending_words != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // The radix may only change while the block is idle, so the pipeline is emptied
    // before the write.
    task automatic set_radix(input logic [b2ra_pkg::BASE_W-1:0] r);
        in_ch.valid <= 1'b0;
        wait_until_drained();
        cfg_we   <= 1'b1;
        cfg_data <= r;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // A mix of tiny numbers, numbers of random length, runs of ones and full-width
    // random numbers, so that both short and long digit strings appear in every radix.
    function automatic logic [b2ra_pkg::VALUE_WIDTH_DEF-1:0] random_number();
        logic [b2ra_pkg::VALUE_WIDTH_DEF-1:0] n;
        case ($urandom_range(0, 3))
            0: begin
                n = $urandom_range(0, 40);
            end
            1: begin
                n = $urandom >> $urandom_range(0, 31);
            end
            2: begin
                n = 32'hFFFF_FFFF >> $urandom_range(0, 31);
            end
            default: begin
                n = $urandom;
            end
        endcase
        return n;
    endfunction

    initial begin
        logic [b2ra_pkg::BASE_W-1:0] phase_radix[7];
        in_ch.valid <= 1'b0;
        in_ch.value <= '0;
        cfg_we      <= 1'b0;
        cfg_data    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words. The first ones run at the reset radix of ten, with no write.
        send_number(32'd0);
        send_number(32'd9);
        send_number(32'd10);
        send_number(32'hFFFF_FFFF);

        set_radix(5'd16);
        send_number(32'd0);
        send_number(32'd15);
        send_number(32'h89AB_CDEF);
        send_number(32'hFFFF_FFFF);

        // Binary gives the longest strings: all 32 digits for the top value.
        set_radix(5'd2);
        send_number(32'd0);
        send_number(32'd1);
        send_number(32'h8000_0000);
        send_number(32'hFFFF_FFFF);

        // A radix below the range is treated as two, one above it as sixteen.
        set_radix(5'd0);
        send_number(32'd6);
        set_radix(5'd1);
        send_number(32'h5A5A_5A5A);
        set_radix(5'd17);
        send_number(32'hFEDC_BA98);
        set_radix(5'd31);
        send_number(32'd255);
        set_radix(5'd3);
        send_number(32'hFFFF_FFFF);
        send_number(32'd0);

        // Random part: several radix settings, one of them drawn at random.
        phase_radix = '{5'd2, 5'd16, 5'd7, 5'd31, 5'd0, 5'd10, 5'd10};
        phase_radix[5] = b2ra_pkg::BASE_W'($urandom_range(0, 31));
        for (int p = 0; p < 7; p++) begin
            set_radix(phase_radix[p]);
            // The long hold-off falls in the second phase; the last phase runs flat out.
            if (p == 1) begin
                hold_request = 1'b1;
            end
            if (p == 6) begin
                idle_on = 1'b0;
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                send_number(random_number());
            end
        end
        in_ch.valid <= 1'b0;

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/b2ra_pkg.sv
rtl/core/b2ra_if.sv
rtl/core/b2ra_cell.sv
rtl/core/binary_to_radix_ascii.sv
tb/b2ra_digit_checker.sv
tb/testbench.sv
